// ----- src/acb_pkg.sv -----
// Shared types and codes for the goto-table builder.
// Request and result structs, op and status codes, controller states,
// and the command/status bundles between controller and datapath.
package acb_pkg;

    localparam logic [2:0] OP_EDGE   = 3'd0;
    localparam logic [2:0] OP_SUFFIX = 3'd1;
    localparam logic [2:0] OP_TERM   = 3'd2;
    localparam logic [2:0] OP_BUILD  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED = 2'd2;

    localparam int LINK_W = 8;
    localparam int CFG_W  = 9;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  state_index;
        logic [7:0]  symbol;
        logic [7:0]  link_value;
        logic [15:0] terminal_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  next_state;
        logic [15:0] terminal_out;
        logic [7:0]  output_link;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RDWAIT,
        S_RESULT,
        S_POP,
        S_POPW,
        S_SUFW,
        S_RDCHILD,
        S_CHILD,
        S_COPY
    } ctrl_state_t;

    typedef struct packed {
        logic       clr_step;
        logic       capture;
        logic       wr_edge;
        logic       wr_suf;
        logic       wr_term;
        logic       rd_item;
        logic       res_read;
        logic       res_load;
        logic [1:0] res_status;
        logic       bld_init;
        logic       pop;
        logic       load_cur;
        logic       load_suf;
        logic       rd_child;
        logic       push;
        logic       rd_copy;
        logic       wr_copy;
        logic       sym_clr;
        logic       sym_step;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       st_ok;
        logic       sym_ok;
        logic       count_zero;
        logic       queue_empty;
        logic       child_nz;
        logic       child_bad;
        logic       suf_bad;
        logic       cur_zero;
        logic       sym_last;
        logic       clear_last;
        logic       out_free;
    } sts_t;

endpackage

// ----- src/acb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/acb_ctrl.sv -----
// Controller state machine for the goto-table builder.
// Depends on acb_pkg; drives datapath commands from datapath status.
module acb_ctrl import acb_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESULT;
                if (sts.op == OP_READ && sts.st_ok && sts.sym_ok)
                begin
                    state_next = S_RDWAIT;
                end
                else if (sts.op == OP_BUILD && !sts.count_zero)
                begin
                    state_next = S_POP;
                end
            end
            S_RDWAIT:  state_next = S_RESULT;
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP:     state_next = sts.queue_empty ? S_RESULT : S_POPW;
            S_POPW:    state_next = S_SUFW;
            S_SUFW:    state_next = S_RDCHILD;
            S_RDCHILD: state_next = S_CHILD;
            S_CHILD:
            begin
                if (sts.child_nz)
                begin
                    if (sts.child_bad)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = sts.sym_last ? S_POP : S_RDCHILD;
                    end
                end
                else if (!sts.cur_zero)
                begin
                    state_next = sts.suf_bad ? S_RESULT : S_COPY;
                end
                else
                begin
                    state_next = sts.sym_last ? S_POP : S_RDCHILD;
                end
            end
            S_COPY:    state_next = sts.sym_last ? S_POP : S_RDCHILD;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:   cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = STATUS_OK;
                case (sts.op)
                    OP_EDGE:
                    begin
                        if (sts.st_ok && sts.sym_ok)
                            cmd.wr_edge = 1'b1;
                        else
                            cmd.res_status = STATUS_RANGE;
                    end
                    OP_SUFFIX:
                    begin
                        if (sts.st_ok)
                            cmd.wr_suf = 1'b1;
                        else
                            cmd.res_status = STATUS_RANGE;
                    end
                    OP_TERM:
                    begin
                        if (sts.st_ok)
                            cmd.wr_term = 1'b1;
                        else
                            cmd.res_status = STATUS_RANGE;
                    end
                    OP_READ:
                    begin
                        if (sts.st_ok && sts.sym_ok)
                        begin
                            cmd.rd_item  = 1'b1;
                            cmd.res_load = 1'b0;
                        end
                        else
                        begin
                            cmd.res_status = STATUS_RANGE;
                        end
                    end
                    OP_BUILD:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.res_status = STATUS_RANGE;
                        end
                        else
                        begin
                            cmd.bld_init = 1'b1;
                            cmd.res_load = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            S_RDWAIT:  cmd.res_read = 1'b1;
            S_RESULT:  cmd.emit = sts.out_free;
            S_POP:
            begin
                if (sts.queue_empty)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STATUS_OK;
                end
                else
                begin
                    cmd.pop = 1'b1;
                end
            end
            S_POPW:
            begin
                cmd.load_cur = 1'b1;
                cmd.sym_clr  = 1'b1;
            end
            S_SUFW:    cmd.load_suf = 1'b1;
            S_RDCHILD: cmd.rd_child = 1'b1;
            S_CHILD:
            begin
                if (sts.child_nz)
                begin
                    if (sts.child_bad)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STATUS_MALFORMED;
                    end
                    else
                    begin
                        cmd.push     = 1'b1;
                        cmd.sym_step = !sts.sym_last;
                    end
                end
                else if (!sts.cur_zero)
                begin
                    if (sts.suf_bad)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STATUS_MALFORMED;
                    end
                    else
                    begin
                        cmd.rd_copy = 1'b1;
                    end
                end
                else
                begin
                    cmd.sym_step = !sts.sym_last;
                end
            end
            S_COPY:
            begin
                cmd.wr_copy  = 1'b1;
                cmd.sym_step = !sts.sym_last;
            end
            default: ;
        endcase
    end

endmodule

// ----- src/acb_dp.sv -----
// Datapath for the goto-table builder: tables, BFS queue, counters, result regs.
// Depends on acb_pkg and acb_ram.
module acb_dp import acb_pkg::*; #(
    parameter int MAX_STATES     = 256,
    parameter int SYMBOL_COUNT   = 256,
    parameter int TERMINAL_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         in_data,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  cmd_t             cmd,
    output sts_t             sts,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data
);

    localparam int SW     = $clog2(MAX_STATES);
    localparam int YW     = $clog2(SYMBOL_COUNT);
    localparam int AW     = SW + YW;
    localparam int TDEPTH = 2 ** AW;
    localparam int CW     = $clog2(MAX_STATES + 1);

    logic [CFG_W-1:0] cfg_count_reg;
    logic [CW-1:0]    count;
    in_item_t         item_reg;
    logic [AW-1:0]    clr_reg;
    logic [CW-1:0]    head_reg, tail_reg;
    logic [7:0]       cur_reg, suf_reg;
    logic [YW-1:0]    sym_reg;
    out_item_t        res_reg, out_reg;
    logic             out_valid_reg;

    logic [SW-1:0]    st_addr;
    logic [YW-1:0]    sym_addr;

    logic                      t_we;
    logic [AW-1:0]             t_waddr, t_raddr;
    logic [LINK_W-1:0]         t_wdata, t_rdata;
    logic [LINK_W-1:0]         s_rdata, o_rdata, q_rdata, q_wdata;
    logic [TERMINAL_WIDTH-1:0] m_rdata;
    logic                      q_we;
    logic [SW-1:0]             q_waddr;

    assign count = (32'(cfg_count_reg) > 32'(MAX_STATES)) ? CW'(MAX_STATES)
                                                          : CW'(cfg_count_reg);
    assign st_addr  = SW'(item_reg.state_index);
    assign sym_addr = YW'(item_reg.symbol);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_count_reg <= CFG_W'(1);
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_count_reg <= cfg_data;
            if (cmd.clr_step)
                clr_reg <= clr_reg + AW'(1);
            if (cmd.bld_init)
            begin
                head_reg <= '0;
                tail_reg <= CW'(1);
            end
            else
            begin
                if (cmd.pop)
                    head_reg <= head_reg + CW'(1);
                if (cmd.push)
                    tail_reg <= tail_reg + CW'(1);
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.load_cur)
            cur_reg <= q_rdata;
        if (cmd.load_suf)
            suf_reg <= s_rdata;
        if (cmd.sym_clr)
            sym_reg <= '0;
        else if (cmd.sym_step)
            sym_reg <= sym_reg + YW'(1);
        if (cmd.res_load)
        begin
            res_reg.next_state   <= '0;
            res_reg.terminal_out <= '0;
            res_reg.output_link  <= '0;
            res_reg.status       <= cmd.res_status;
        end
        else if (cmd.res_read)
        begin
            res_reg.next_state   <= t_rdata;
            res_reg.terminal_out <= 16'(m_rdata);
            res_reg.output_link  <= o_rdata;
            res_reg.status       <= STATUS_OK;
        end
        if (cmd.emit)
            out_reg <= res_reg;
    end

    // goto table: clear pass, edge writes and build copies share the write port
    always_comb
    begin
        t_we    = cmd.clr_step | cmd.wr_edge | cmd.wr_copy;
        t_waddr = clr_reg;
        t_wdata = '0;
        if (cmd.wr_edge)
        begin
            t_waddr = {st_addr, sym_addr};
            t_wdata = item_reg.link_value;
        end
        else if (cmd.wr_copy)
        begin
            t_waddr = {SW'(cur_reg), sym_reg};
            t_wdata = t_rdata;
        end
        if (cmd.rd_child)
            t_raddr = {SW'(cur_reg), sym_reg};
        else if (cmd.rd_copy)
            t_raddr = {SW'(suf_reg), sym_reg};
        else
            t_raddr = {st_addr, sym_addr};
    end

    assign q_we    = cmd.bld_init | cmd.push;
    assign q_waddr = cmd.bld_init ? '0 : tail_reg[SW-1:0];
    assign q_wdata = cmd.bld_init ? '0 : t_rdata;

    acb_ram #(.WIDTH(LINK_W), .DEPTH(TDEPTH)) u_goto (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    acb_ram #(.WIDTH(LINK_W), .DEPTH(2 ** SW)) u_suffix (
        .clk(clk), .we(cmd.wr_suf), .waddr(st_addr), .wdata(item_reg.link_value),
        .raddr(SW'(q_rdata)), .rdata(s_rdata)
    );

    acb_ram #(.WIDTH(TERMINAL_WIDTH), .DEPTH(2 ** SW)) u_term (
        .clk(clk), .we(cmd.wr_term), .waddr(st_addr),
        .wdata(TERMINAL_WIDTH'(item_reg.terminal_value)),
        .raddr(st_addr), .rdata(m_rdata)
    );

    acb_ram #(.WIDTH(LINK_W), .DEPTH(2 ** SW)) u_olink (
        .clk(clk), .we(cmd.wr_term), .waddr(st_addr), .wdata(item_reg.link_value),
        .raddr(st_addr), .rdata(o_rdata)
    );

    acb_ram #(.WIDTH(LINK_W), .DEPTH(2 ** SW)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(head_reg[SW-1:0]), .rdata(q_rdata)
    );

    always_comb
    begin
        sts.op          = item_reg.op;
        sts.st_ok       = 32'(item_reg.state_index) < 32'(count);
        sts.sym_ok      = 32'(item_reg.symbol) < 32'(SYMBOL_COUNT);
        sts.count_zero  = (count == '0);
        sts.queue_empty = (head_reg == tail_reg);
        sts.child_nz    = |t_rdata;
        sts.child_bad   = (32'(t_rdata) >= 32'(count)) || (32'(tail_reg) >= 32'(count));
        sts.suf_bad     = 32'(suf_reg) >= 32'(count);
        sts.cur_zero    = (cur_reg == '0);
        sts.sym_last    = (sym_reg == YW'(SYMBOL_COUNT - 1));
        sts.clear_last  = &clr_reg;
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- src/aho_corasick_dfa_builder.sv -----
// Top level of the Aho-Corasick goto-table builder.
// Depends on acb_pkg, acb_ctrl and acb_dp.
//
// Usage:
//  - Requests arrive on in_valid/in_ready with an in_item_t payload: edge,
//    suffix-link and terminal writes, a build, and reads. Every request
//    returns exactly one out_item_t on out_valid/out_ready.
//  - cfg_we/cfg_data set the number of states in use; write only while idle.
//  - A result goes through the DECODE and RESULT states, in-range reads also
//    through RDWAIT; the next request is taken once RESULT hands it on.
//  - A build walks the trie breadth first: each dequeued state passes POP,
//    POPW and SUFW, then each of its symbols passes RDCHILD and CHILD (one
//    goto-table read, and on a missing edge of a non-root state a second
//    read and a write-back in COPY), all through the single read port.
//  - After reset the goto table is cleared one entry a cycle, covering all
//    2**clog2(MAX_STATES) * 2**clog2(SYMBOL_COUNT) entries (65536 at
//    defaults); in_ready stays low during that pass.
//  - A finished result sits in an output register; the next request is
//    accepted while it waits. If the receiver stalls, the following result
//    is held until the output register frees.
module aho_corasick_dfa_builder import acb_pkg::*; #(
    parameter int MAX_STATES     = 256,
    parameter int SYMBOL_COUNT   = 256,
    parameter int TERMINAL_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    acb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .sts(sts), .cmd(cmd)
    );

    acb_dp #(
        .MAX_STATES(MAX_STATES),
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .TERMINAL_WIDTH(TERMINAL_WIDTH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_we),
        .cfg_data(cfg_data), .cmd(cmd), .sts(sts), .out_valid(out_valid),
        .out_ready(out_ready), .out_data(out_data)
    );

endmodule
